// ----- rtl/rdpr_pkg.sv -----
package rdpr_pkg;

  localparam int BUFFER_BYTES = 256;
  localparam int LIMIT_CAP_INT = (BUFFER_BYTES - 4 < 252) ? BUFFER_BYTES - 4 : 252;
  localparam logic [7:0] LIMIT_CAP = 8'(LIMIT_CAP_INT);
  localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd252;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUERY  = 8'h3F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_BYTE     = 3'd1;
  localparam logic [2:0] EV_GOOD     = 3'd2;
  localparam logic [2:0] EV_BAD      = 3'd3;
  localparam logic [2:0] EV_NOSTART  = 3'd4;
  localparam logic [2:0] EV_OVERFLOW = 3'd5;

  localparam logic [1:0] ACK_NONE = 2'd0;
  localparam logic [1:0] ACK_POS  = 2'd1;
  localparam logic [1:0] ACK_NEG  = 2'd2;

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_PAYLOAD = 5'b00010,
    PH_DIG_HI  = 5'b00100,
    PH_DIG_LO  = 5'b01000,
    PH_DISCARD = 5'b10000
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] running_sum;
    logic [7:0] payload_count;
    logic [3:0] high_digit;
    logic       digit_fault;
    logic       first_was_query;
  } state_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] payload_byte;
    logic [7:0] packet_length;
    logic [1:0] reply_ack;
    logic       is_query;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  localparam state_t STATE_RESET = '{
    phase: PH_HUNT, running_sum: 8'd0, payload_count: 8'd0,
    high_digit: 4'd0, digit_fault: 1'b0, first_was_query: 1'b0
  };

  localparam state_t STATE_START = '{
    phase: PH_PAYLOAD, running_sum: 8'd0, payload_count: 8'd0,
    high_digit: 4'd0, digit_fault: 1'b0, first_was_query: 1'b0
  };

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t       h;
    logic [7:0] t;
    h = '0;
    t = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
      h.ok = 1'b1;
    end else if (c >= CH_LA && c <= CH_LF) begin
      t = c - CH_LA + 8'd10;
      h.ok = 1'b1;
    end else if (c >= CH_UA && c <= CH_UF) begin
      t = c - CH_UA + 8'd10;
      h.ok = 1'b1;
    end
    h.value = t[3:0];
    return h;
  endfunction

endpackage

// ----- rtl/remote_debug_packet_receiver.sv -----
// Channel | Direction | Handshake          | Beat
// input   | in        | in_valid/in_stall  | rx_byte
// result  | out       | out_valid/out_stall| event_res, payload_byte, packet_length,
//         |           |                    | reply_ack, is_query
// config  | in        | cfg_valid/cfg_ready| cfg_data (max_payload)
//
// One beat per cycle sustained while out_stall is low; a beat passes the input register, then the result register.
// The frame state updates in the single step between input register and result register.
// Reset (synchronous, rst high) empties both registers, clears frame state, limit 252.
// A stall on the result side holds both stages; in_stall follows it combinationally.
module remote_debug_packet_receiver import rdpr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] event_res,
  output logic [7:0] payload_byte,
  output logic [7:0] packet_length,
  output logic [1:0] reply_ack,
  output logic       is_query,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic       in_reg_valid;
  logic [7:0] in_reg_byte;
  logic [7:0] max_payload;
  state_t     st;
  state_t     st_next;
  result_t    res_next;
  result_t    res;
  logic       advance;

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = in_reg_valid && !advance;
  assign cfg_ready = 1'b1;

  rdpr_step u_step (
    .st          (st),
    .rx_byte     (in_reg_byte),
    .max_payload (max_payload),
    .st_next     (st_next),
    .res         (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_payload <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= STATE_RESET;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_reg_valid;
      if (in_reg_valid) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_reg_valid) begin
      res <= res_next;
    end
  end

  assign event_res     = res.event_res;
  assign payload_byte  = res.payload_byte;
  assign packet_length = res.packet_length;
  assign reply_ack     = res.reply_ack;
  assign is_query      = res.is_query;

endmodule

// ----- rtl/rdpr_step.sv -----
module rdpr_step import rdpr_pkg::*; (
  input  state_t     st,
  input  logic [7:0] rx_byte,
  input  logic [7:0] max_payload,
  output state_t     st_next,
  output result_t    res
);

  logic [7:0] limit;
  hex_t       digit;
  logic       sum_match;

  assign limit     = (max_payload > LIMIT_CAP) ? LIMIT_CAP : max_payload;
  assign digit     = hex_value(rx_byte);
  assign sum_match = ({st.high_digit, digit.value} == st.running_sum);

  always_comb begin
    st_next = st;
    res     = '0;
    unique case (st.phase)
      PH_PAYLOAD: begin
        if (rx_byte == CH_HASH) begin
          st_next.phase = PH_DIG_HI;
        end else if (st.payload_count >= limit) begin
          res.event_res     = EV_OVERFLOW;
          res.packet_length = st.payload_count;
          st_next.phase     = PH_DISCARD;
        end else begin
          if (st.payload_count == 8'd0) begin
            st_next.first_was_query = (rx_byte == CH_QUERY);
          end
          st_next.running_sum   = st.running_sum + rx_byte;
          st_next.payload_count = st.payload_count + 8'd1;
          res.event_res         = EV_BYTE;
          res.payload_byte      = rx_byte;
        end
      end
      PH_DIG_HI: begin
        st_next.digit_fault = !digit.ok;
        st_next.high_digit  = digit.value;
        st_next.phase       = PH_DIG_LO;
      end
      PH_DIG_LO: begin
        res.packet_length = st.payload_count;
        if (digit.ok && !st.digit_fault && sum_match) begin
          res.event_res = EV_GOOD;
          res.reply_ack = ACK_POS;
          res.is_query  = (st.payload_count == 8'd1) && st.first_was_query;
        end else begin
          res.event_res = EV_BAD;
          res.reply_ack = ACK_NEG;
        end
        st_next.phase = PH_HUNT;
      end
      PH_DISCARD: begin
        if (rx_byte == CH_DOLLAR) begin
          st_next = STATE_START;
        end else if (rx_byte == CH_HASH) begin
          st_next.phase = PH_HUNT;
        end
      end
      default: begin
        if (rx_byte == CH_DOLLAR) begin
          st_next = STATE_START;
        end else begin
          st_next.phase = PH_HUNT;
          if (rx_byte == CH_HASH) begin
            res.event_res = EV_NOSTART;
            res.reply_ack = ACK_NEG;
          end
        end
      end
    endcase
  end

endmodule

// ----- rtl/rdpr_checker.sv -----
module rdpr_checker import rdpr_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] event_res,
  input logic [7:0] packet_length,
  input logic [1:0] reply_ack,
  input logic       is_query
);

  property p_reset_empties;
    @(posedge clk) rst |=> !out_valid;
  endproperty
  a_reset_empties: assert property (p_reset_empties) else $error("result after reset");

  property p_hold;
    @(posedge clk) disable iff (rst)
      out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(reply_ack);
  endproperty
  a_hold: assert property (p_hold) else $error("stalled result beat changed");

  property p_good_ack;
    @(posedge clk) disable iff (rst)
      out_valid |-> ((event_res == EV_GOOD) == (reply_ack == ACK_POS));
  endproperty
  a_good_ack: assert property (p_good_ack) else $error("positive ack mismatch");

  property p_neg_ack;
    @(posedge clk) disable iff (rst)
      out_valid && reply_ack == ACK_NEG |-> (event_res == EV_BAD || event_res == EV_NOSTART);
  endproperty
  a_neg_ack: assert property (p_neg_ack) else $error("negative ack on wrong event");

  property p_query;
    @(posedge clk) disable iff (rst)
      out_valid && is_query |-> event_res == EV_GOOD && packet_length == 8'd1;
  endproperty
  a_query: assert property (p_query) else $error("query flag on wrong packet");

endmodule

bind remote_debug_packet_receiver rdpr_checker u_rdpr_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .event_res     (event_res),
  .packet_length (packet_length),
  .reply_ack     (reply_ack),
  .is_query      (is_query)
);
